// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the top-level filter unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition that must hold at every edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`endif

// ----- rtl/dctl_pkg.sv -----
package dctl_pkg;

    localparam int TIMER_BITS = 16;
    localparam int TIMEOUT_W  = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int SAT_W      = (TIMER_BITS > TIMEOUT_W) ? TIMER_BITS : TIMEOUT_W;

    localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Event opcodes
    localparam logic [2:0] OP_KEY_DOWN     = 3'd0;
    localparam logic [2:0] OP_KEY_UP       = 3'd1;
    localparam logic [2:0] OP_MOUSE_MOVE   = 3'd2;
    localparam logic [2:0] OP_MOUSE_BUTTON = 3'd3;
    localparam logic [2:0] OP_TICK         = 3'd4;
    localparam logic [2:0] OP_UNKNOWN      = 3'd5;

    // Key classes
    localparam logic [1:0] KC_LCTRL = 2'd1;
    localparam logic [1:0] KC_LALT  = 2'd2;

    // Injected keys
    localparam logic [1:0] KEY_NONE  = 2'd0;
    localparam logic [1:0] KEY_ESC   = 2'd1;
    localparam logic [1:0] KEY_RCTRL = 2'd2;
    localparam logic [1:0] KEY_LCTRL = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FLUSH_KEY   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FLUSH_MOUSE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DRAG_FIX    = 2'd3;

    // One classified event: up to two injections followed by the verdict.
    typedef struct packed {
        logic [1:0] cnt;
        logic [1:0] key0;
        logic       rel0;
        logic [1:0] key1;
        logic       rel1;
        logic       blk;
    } cmd_t;

    typedef struct packed {
        logic held;
        logic fwd;
    } status_t;

endpackage

// ----- rtl/dual_role_ctrl_key_filter_unit.sv -----
// Dual-role left-Ctrl filter: a tap yields Escape, a hold yields Ctrl.
// Request channel (req_valid/req_ready) carries one event per transfer:
// opcode and key_class. Response channel (rsp_valid/rsp_ready) returns zero
// to two injected key items followed by one verdict item with last set and
// block_original giving pass or swallow for the original event.
// Configuration is written through cfg_we/cfg_index/cfg_wdata, one register
// per cycle, while the block is idle; the user must keep to this, as the block leaves it unchecked.
// The back end emits one result per cycle while the receiver takes them, and
// an event yields one to three results; the front end classifies one event
// per cycle, while the queue is not full, into a four-entry command queue,
// so short bursts are absorbed.
// When the receiver stalls, the output register holds its item, the queue
// fills, and req_ready drops once all four entries are taken.
// Reset clears all tracking state, empties the queue and the output register,
// and restores the default configuration (timeout off, all flush triggers
// and the drag fix on).
`include "assert_macros.svh"

module dual_role_ctrl_key_filter_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [dctl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dctl_pkg::TIMEOUT_W-1:0]   cfg_wdata,
    input  logic                             req_valid,
    output logic                             req_ready,
    input  logic [2:0]                       opcode,
    input  logic [1:0]                       key_class,
    output logic                             rsp_valid,
    input  logic                             rsp_ready,
    output logic [1:0]                       inject_key,
    output logic                             inject_release,
    output logic                             block_original,
    output logic                             last
);

    dctl_pkg::cmd_t    front_cmd;
    dctl_pkg::cmd_t    queue_head;
    dctl_pkg::status_t front_status;
    logic              take;
    logic              q_full;
    logic              q_empty;
    logic              q_pop;

    assign req_ready = !q_full;
    assign take      = req_valid && req_ready;

    dctl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .take      (take),
        .opcode    (opcode),
        .key_class (key_class),
        .cmd       (front_cmd),
        .status    (front_status)
    );

    dctl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (take),
        .push_data (front_cmd),
        .pop       (q_pop),
        .head      (queue_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    dctl_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (queue_head),
        .empty          (q_empty),
        .pop            (q_pop),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .inject_key     (inject_key),
        .inject_release (inject_release),
        .block_original (block_original),
        .last           (last)
    );

    `ASSERT_IMPLY(a_verdict_clean, clk, rst_n, rsp_valid && last, inject_key == dctl_pkg::KEY_NONE && !inject_release, "verdict item carries an injected key")
    `ASSERT_IMPLY(a_inject_clean, clk, rst_n, rsp_valid && !last, inject_key != dctl_pkg::KEY_NONE && !block_original, "injection item malformed")
    `ASSERT_ALWAYS(a_ctrl_exclusive, clk, rst_n, !(front_status.held && front_status.fwd), "ctrl both held back and forwarded")

endmodule

// ----- rtl/dctl_front.sv -----
module dctl_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [dctl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dctl_pkg::TIMEOUT_W-1:0]      cfg_wdata,
    input  logic                                take,
    input  logic [2:0]                          opcode,
    input  logic [1:0]                          key_class,
    output dctl_pkg::cmd_t                      cmd,
    output dctl_pkg::status_t                   status
);

    logic [dctl_pkg::TIMEOUT_W-1:0]  timeout_reg;
    logic                            flush_key_reg;
    logic                            flush_mouse_reg;
    logic                            drag_fix_reg;

    logic                            held_reg, held_next;
    logic                            fwd_reg, fwd_next;
    logic                            alt_reg, alt_next;
    logic                            drag_seen_reg, drag_seen_next;
    logic                            drag_seq_reg, drag_seq_next;
    logic                            armed_reg, armed_next;
    logic [dctl_pkg::TIMER_BITS-1:0] remain_reg, remain_next;

    logic [dctl_pkg::SAT_W-1:0]      timeout_wide;
    logic [dctl_pkg::TIMER_BITS-1:0] timer_load;

    always_comb
    begin
        timeout_wide = dctl_pkg::SAT_W'(timeout_reg);
        if (timeout_wide > dctl_pkg::SAT_W'(dctl_pkg::TIMER_MAX))
        begin
            timer_load = dctl_pkg::TIMER_MAX;
        end
        else
        begin
            timer_load = dctl_pkg::TIMER_BITS'(timeout_wide);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg     <= '0;
            flush_key_reg   <= 1'b1;
            flush_mouse_reg <= 1'b1;
            drag_fix_reg    <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dctl_pkg::REG_TIMEOUT:     timeout_reg     <= cfg_wdata;
                dctl_pkg::REG_FLUSH_KEY:   flush_key_reg   <= cfg_wdata[0];
                dctl_pkg::REG_FLUSH_MOUSE: flush_mouse_reg <= cfg_wdata[0];
                dctl_pkg::REG_DRAG_FIX:    drag_fix_reg    <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        held_next      = held_reg;
        fwd_next       = fwd_reg;
        alt_next       = alt_reg;
        drag_seen_next = drag_seen_reg;
        drag_seq_next  = drag_seq_reg;
        armed_next     = armed_reg;
        remain_next    = remain_reg;
        cmd            = '0;

        case (opcode) inside
            dctl_pkg::OP_KEY_DOWN:
            begin
                if (key_class == dctl_pkg::KC_LCTRL)
                begin
                    cmd.blk = 1'b1;
                    if (!held_reg && !fwd_reg)
                    begin
                        held_next = 1'b1;
                        if (timeout_reg != '0)
                        begin
                            armed_next  = 1'b1;
                            remain_next = timer_load;
                        end
                    end
                end
                else if (key_class == dctl_pkg::KC_LALT)
                begin
                    alt_next = 1'b1;
                    cmd.blk  = alt_reg;
                end
                else if (flush_key_reg && held_reg)
                begin
                    held_next = 1'b0;
                    fwd_next  = 1'b1;
                    cmd.cnt   = 2'd1;
                    cmd.key0  = dctl_pkg::KEY_LCTRL;
                end
            end
            dctl_pkg::OP_KEY_UP:
            begin
                if (key_class == dctl_pkg::KC_LCTRL)
                begin
                    cmd.blk = 1'b1;
                    if (held_reg)
                    begin
                        held_next = 1'b0;
                        if (!drag_fix_reg || (!alt_reg && !drag_seq_reg))
                        begin
                            // bare tap: Escape press and release
                            cmd.cnt     = 2'd2;
                            cmd.key0    = dctl_pkg::KEY_ESC;
                            cmd.key1    = dctl_pkg::KEY_ESC;
                            cmd.rel1    = 1'b1;
                            armed_next  = 1'b0;
                            remain_next = '0;
                        end
                        else if (alt_reg)
                        begin
                            drag_seq_next = 1'b1;
                        end
                        else
                        begin
                            drag_seq_next = 1'b0;
                            cmd.cnt       = 2'd2;
                            cmd.key0      = dctl_pkg::KEY_RCTRL;
                            cmd.key1      = dctl_pkg::KEY_RCTRL;
                            cmd.rel1      = 1'b1;
                        end
                    end
                    else if (fwd_reg)
                    begin
                        fwd_next = 1'b0;
                        cmd.cnt  = 2'd1;
                        cmd.key0 = dctl_pkg::KEY_LCTRL;
                        cmd.rel0 = 1'b1;
                    end
                end
                else if (key_class == dctl_pkg::KC_LALT)
                begin
                    alt_next       = 1'b0;
                    drag_seen_next = 1'b0;
                    if (drag_seen_reg)
                    begin
                        drag_seq_next = 1'b1;
                    end
                end
            end
            dctl_pkg::OP_MOUSE_MOVE,
            dctl_pkg::OP_MOUSE_BUTTON:
            begin
                if (flush_mouse_reg)
                begin
                    if (opcode == dctl_pkg::OP_MOUSE_BUTTON && alt_reg)
                    begin
                        drag_seen_next = 1'b1;
                    end
                    if (held_reg)
                    begin
                        held_next = 1'b0;
                        fwd_next  = 1'b1;
                        cmd.cnt   = 2'd1;
                        cmd.key0  = dctl_pkg::KEY_LCTRL;
                    end
                end
            end
            dctl_pkg::OP_TICK:
            begin
                cmd.blk = 1'b1;
                if (armed_reg)
                begin
                    if (remain_reg <= dctl_pkg::TIMER_BITS'(1))
                    begin
                        armed_next  = 1'b0;
                        remain_next = '0;
                        if (held_reg)
                        begin
                            held_next = 1'b0;
                            fwd_next  = 1'b1;
                            cmd.cnt   = 2'd1;
                            cmd.key0  = dctl_pkg::KEY_LCTRL;
                        end
                    end
                    else
                    begin
                        remain_next = remain_reg - dctl_pkg::TIMER_BITS'(1);
                    end
                end
            end
            dctl_pkg::OP_UNKNOWN:
            begin
                cmd.blk = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= 1'b0;
            fwd_reg       <= 1'b0;
            alt_reg       <= 1'b0;
            drag_seen_reg <= 1'b0;
            drag_seq_reg  <= 1'b0;
            armed_reg     <= 1'b0;
            remain_reg    <= '0;
        end
        else if (take)
        begin
            held_reg      <= held_next;
            fwd_reg       <= fwd_next;
            alt_reg       <= alt_next;
            drag_seen_reg <= drag_seen_next;
            drag_seq_reg  <= drag_seq_next;
            armed_reg     <= armed_next;
            remain_reg    <= remain_next;
        end
    end

    assign status.held = held_reg;
    assign status.fwd  = fwd_reg;

endmodule

// ----- rtl/dctl_queue.sv -----
module dctl_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  dctl_pkg::cmd_t                push_data,
    input  logic                          pop,
    output dctl_pkg::cmd_t                head,
    output logic                          full,
    output logic                          empty
);

    dctl_pkg::cmd_t                  entry_reg [dctl_pkg::QUEUE_DEPTH];
    logic [dctl_pkg::QUEUE_AW-1:0]   wr_ptr_reg;
    logic [dctl_pkg::QUEUE_AW-1:0]   rd_ptr_reg;
    logic [dctl_pkg::QUEUE_CW-1:0]   count_reg;

    assign full  = (count_reg == dctl_pkg::QUEUE_CW'(dctl_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + dctl_pkg::QUEUE_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + dctl_pkg::QUEUE_AW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + dctl_pkg::QUEUE_CW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - dctl_pkg::QUEUE_CW'(1);
            end
        end
    end

endmodule

// ----- rtl/dctl_back.sv -----
module dctl_back (
    input  logic            clk,
    input  logic            rst_n,
    input  dctl_pkg::cmd_t  head,
    input  logic            empty,
    output logic            pop,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output logic [1:0]      inject_key,
    output logic            inject_release,
    output logic            block_original,
    output logic            last
);

    logic       valid_reg;
    logic [1:0] idx_reg, idx_next;
    logic [1:0] key_reg, key_next;
    logic       rel_reg, rel_next;
    logic       blk_reg, blk_next;
    logic       last_reg, last_next;
    logic       load;

    // Output register takes a new item from a non-empty queue when it is empty or being drained.
    assign load = !empty && (!valid_reg || rsp_ready);

    always_comb
    begin
        key_next  = dctl_pkg::KEY_NONE;
        rel_next  = 1'b0;
        blk_next  = 1'b0;
        last_next = 1'b0;
        idx_next  = idx_reg + 2'd1;
        pop       = 1'b0;
        if (idx_reg == head.cnt)
        begin
            blk_next  = head.blk;
            last_next = 1'b1;
            idx_next  = '0;
            pop       = load;
        end
        else if (idx_reg == 2'd0)
        begin
            key_next = head.key0;
            rel_next = head.rel0;
        end
        else
        begin
            key_next = head.key1;
            rel_next = head.rel1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= idx_next;
        end
        else if (rsp_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            key_reg  <= key_next;
            rel_reg  <= rel_next;
            blk_reg  <= blk_next;
            last_reg <= last_next;
        end
    end

    assign rsp_valid      = valid_reg;
    assign inject_key     = key_reg;
    assign inject_release = rel_reg;
    assign block_original = blk_reg;
    assign last           = last_reg;

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    // Opcodes and key classes that have no name in the package
    localparam logic [2:0] OP_OTHER_MSG = 3'd6;
    localparam logic [2:0] OP_SPARE     = 3'd7;
    localparam logic [1:0] KC_OTHER     = 2'd0;
    localparam logic [1:0] KC_SPARE     = 2'd3;

    localparam int HOLD_CYCLES = 200;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [2:0] op;
        logic [1:0] kc;
    } key_event_t;

    typedef struct packed {
        logic [1:0] key;
        logic       rel;
        logic       blk;
        logic       last;
    } filter_out_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_we = 1'b0;
    logic [dctl_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [dctl_pkg::TIMEOUT_W-1:0] cfg_wdata = '0;
    logic                           req_valid = 1'b0;
    logic                           req_ready;
    logic [2:0]                     opcode = '0;
    logic [1:0]                     key_class = '0;
    logic                           rsp_valid;
    logic                           rsp_ready = 1'b0;
    logic [1:0]                     inject_key;
    logic                           inject_release;
    logic                           block_original;
    logic                           last;

    dual_role_ctrl_key_filter_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .opcode         (opcode),
        .key_class      (key_class),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .inject_key     (inject_key),
        .inject_release (inject_release),
        .block_original (block_original),
        .last           (last)
    );

    always #6 clk = ~clk;

    key_event_t  pending_events[$];
    filter_out_t expected_out[$];
    key_event_t  next_ev;
    filter_out_t got_out;
    filter_out_t want_out;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_requests  = 0;
    int holds_served   = 0;
    int hold_left      = 0;
    int mismatches     = 0;
    int cycle_count    = 0;

    // Predictor configuration
    logic [dctl_pkg::TIMEOUT_W-1:0] cfg_timeout     = '0;
    logic                           cfg_flush_key   = 1'b1;
    logic                           cfg_flush_mouse = 1'b1;
    logic                           cfg_drag_fix    = 1'b1;

    // Predictor state
    logic                            held       = 1'b0;
    logic                            fwd        = 1'b0;
    logic                            alt_held   = 1'b0;
    logic                            drag_seen  = 1'b0;
    logic                            drag_seq   = 1'b0;
    logic                            tmr_armed  = 1'b0;
    logic [dctl_pkg::TIMER_BITS-1:0] tmr_left   = '0;

    function automatic void emit(logic [1:0] k, logic r, logic b, logic l);
        filter_out_t item;
        item.key  = k;
        item.rel  = r;
        item.blk  = b;
        item.last = l;
        expected_out.push_back(item);
    endfunction

    // Turn a held-back Ctrl into a real left-Ctrl press
    function automatic void release_held_ctrl();
        if (held)
        begin
            held = 1'b0;
            fwd  = 1'b1;
            emit(dctl_pkg::KEY_LCTRL, 1'b0, 1'b0, 1'b0);
        end
    endfunction

    function automatic void predict_filter(logic [2:0] op, logic [1:0] kc);
        logic blk;
        blk = 1'b0;
        if (op == dctl_pkg::OP_KEY_DOWN && kc == dctl_pkg::KC_LCTRL)
        begin
            if (!held && !fwd)
            begin
                held = 1'b1;
                if (cfg_timeout != '0)
                begin
                    tmr_armed = 1'b1;
                    tmr_left  = (cfg_timeout > dctl_pkg::TIMER_MAX)
                              ? dctl_pkg::TIMER_MAX
                              : dctl_pkg::TIMER_BITS'(cfg_timeout);
                end
            end
            blk = 1'b1;
        end
        else if (op == dctl_pkg::OP_KEY_UP && kc == dctl_pkg::KC_LCTRL)
        begin
            blk = 1'b1;
            if (held)
            begin
                held = 1'b0;
                if (!cfg_drag_fix || (!alt_held && !drag_seq))
                begin
                    emit(dctl_pkg::KEY_ESC, 1'b0, 1'b0, 1'b0);
                    emit(dctl_pkg::KEY_ESC, 1'b1, 1'b0, 1'b0);
                    tmr_armed = 1'b0;
                    tmr_left  = '0;
                end
                else if (alt_held)
                begin
                    drag_seq = 1'b1;
                end
                else
                begin
                    drag_seq = 1'b0;
                    emit(dctl_pkg::KEY_RCTRL, 1'b0, 1'b0, 1'b0);
                    emit(dctl_pkg::KEY_RCTRL, 1'b1, 1'b0, 1'b0);
                end
            end
            else if (fwd)
            begin
                fwd = 1'b0;
                emit(dctl_pkg::KEY_LCTRL, 1'b1, 1'b0, 1'b0);
            end
        end
        else if (op == dctl_pkg::OP_KEY_DOWN && kc == dctl_pkg::KC_LALT)
        begin
            if (!alt_held)
                alt_held = 1'b1;
            else
                blk = 1'b1;
        end
        else if (op == dctl_pkg::OP_KEY_UP && kc == dctl_pkg::KC_LALT)
        begin
            alt_held = 1'b0;
            if (drag_seen)
                drag_seq = 1'b1;
            drag_seen = 1'b0;
        end
        else if (op == dctl_pkg::OP_KEY_DOWN)
        begin
            if (cfg_flush_key)
                release_held_ctrl();
        end
        else if (op == dctl_pkg::OP_MOUSE_MOVE)
        begin
            if (cfg_flush_mouse)
                release_held_ctrl();
        end
        else if (op == dctl_pkg::OP_MOUSE_BUTTON)
        begin
            if (cfg_flush_mouse)
            begin
                if (alt_held)
                    drag_seen = 1'b1;
                release_held_ctrl();
            end
        end
        else if (op == dctl_pkg::OP_TICK)
        begin
            blk = 1'b1;
            if (tmr_armed)
            begin
                if (tmr_left <= 1)
                begin
                    tmr_armed = 1'b0;
                    tmr_left  = '0;
                    release_held_ctrl();
                end
                else
                begin
                    tmr_left = tmr_left - 1'b1;
                end
            end
        end
        else if (op == dctl_pkg::OP_UNKNOWN)
        begin
            blk = 1'b1;
        end
        emit(dctl_pkg::KEY_NONE, 1'b0, blk, 1'b1);
    endfunction

    // Driver: one event per transfer, valid held until accepted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            opcode    <= '0;
            key_class <= '0;
        end
        else if (!req_valid || req_ready)
        begin
            if (pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_ev = pending_events.pop_front();
                req_valid <= 1'b1;
                opcode    <= next_ev.op;
                key_class <= next_ev.kc;
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls plus long hold-offs on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
        end
        else if (hold_requests != holds_served)
        begin
            holds_served <= holds_served + 1;
            hold_left    <= HOLD_CYCLES;
            rsp_ready    <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
        end
        else
        begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: check each result transfer, predict on each request transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                got_out.key  = inject_key;
                got_out.rel  = inject_release;
                got_out.blk  = block_original;
                got_out.last = last;
                if (expected_out.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result key=%0d rel=%0b blk=%0b last=%0b",
                                 $realtime, got_out.key, got_out.rel, got_out.blk,
                                 got_out.last);
                end
                else
                begin
                    want_out = expected_out.pop_front();
                    if (got_out.key !== want_out.key || got_out.rel !== want_out.rel ||
                        got_out.blk !== want_out.blk || got_out.last !== want_out.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("%0t: mismatch exp key=%0d rel=%0b blk=%0b last=%0b",
                                     $realtime, want_out.key, want_out.rel, want_out.blk,
                                     want_out.last);
                            $display("%0t:          got key=%0d rel=%0b blk=%0b last=%0b",
                                     $realtime, got_out.key, got_out.rel, got_out.blk,
                                     got_out.last);
                        end
                    end
                end
            end
            if (req_valid && req_ready)
                predict_filter(opcode, key_class);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic void add_event(logic [2:0] op, logic [1:0] kc);
        key_event_t ev;
        ev.op = op;
        ev.kc = kc;
        pending_events.push_back(ev);
    endfunction

    // Something that may happen while Ctrl is down, biased toward ticks
    function automatic void add_filler();
        int r;
        r = $urandom_range(9);
        case (r) inside
            [0:3]:   add_event(dctl_pkg::OP_TICK, 2'($urandom_range(3)));
            4:       add_event(dctl_pkg::OP_KEY_DOWN, $urandom_range(1) ? KC_OTHER : KC_SPARE);
            5:       add_event(dctl_pkg::OP_KEY_UP, $urandom_range(1) ? KC_OTHER : KC_SPARE);
            6:       add_event(dctl_pkg::OP_MOUSE_MOVE, 2'($urandom_range(3)));
            7:       add_event(dctl_pkg::OP_MOUSE_BUTTON, 2'($urandom_range(3)));
            8:       add_event($urandom_range(1) ? dctl_pkg::OP_KEY_DOWN : dctl_pkg::OP_KEY_UP,
                               dctl_pkg::KC_LALT);
            default: add_event(dctl_pkg::OP_KEY_DOWN, dctl_pkg::KC_LCTRL);
        endcase
    endfunction

    function automatic int add_random_events(int count);
        int added;
        int fill;
        logic with_alt;
        added = 0;
        while (added < count)
        begin
            if ($urandom_range(99) < 70)
            begin
                with_alt = ($urandom_range(3) == 0);
                if (with_alt)
                    add_event(dctl_pkg::OP_KEY_DOWN, dctl_pkg::KC_LALT);
                add_event(dctl_pkg::OP_KEY_DOWN, dctl_pkg::KC_LCTRL);
                fill = $urandom_range(4);
                for (int i = 0; i < fill; i++)
                    add_filler();
                add_event(dctl_pkg::OP_KEY_UP, dctl_pkg::KC_LCTRL);
                added += fill + 2 + (with_alt ? 1 : 0);
                if (with_alt && $urandom_range(1))
                begin
                    add_event(dctl_pkg::OP_KEY_UP, dctl_pkg::KC_LALT);
                    added++;
                end
            end
            else
            begin
                add_event(3'($urandom_range(7)), 2'($urandom_range(3)));
                added++;
            end
        end
        return added;
    endfunction

    // Sample after the edge settles so a transfer picked at this edge is seen
    task automatic wait_idle();
        do
        begin
            @(posedge clk);
            #1;
        end
        while (pending_events.size() != 0 || req_valid || expected_out.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [dctl_pkg::CFG_IDX_W-1:0] idx,
                             logic [dctl_pkg::TIMEOUT_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            dctl_pkg::REG_TIMEOUT:     cfg_timeout     = val;
            dctl_pkg::REG_FLUSH_KEY:   cfg_flush_key   = val[0];
            dctl_pkg::REG_FLUSH_MOUSE: cfg_flush_mouse = val[0];
            dctl_pkg::REG_DRAG_FIX:    cfg_drag_fix    = val[0];
            default:                   ;
        endcase
    endtask

    task automatic run_phase(logic [dctl_pkg::TIMEOUT_W-1:0] timeout, logic flush_key,
                             logic flush_mouse, logic drag_fix, int send_idle,
                             int recv_stall, logic long_hold);
        write_reg(dctl_pkg::REG_TIMEOUT, timeout);
        write_reg(dctl_pkg::REG_FLUSH_KEY, {{(dctl_pkg::TIMEOUT_W-1){1'b0}}, flush_key});
        write_reg(dctl_pkg::REG_FLUSH_MOUSE, {{(dctl_pkg::TIMEOUT_W-1){1'b0}}, flush_mouse});
        write_reg(dctl_pkg::REG_DRAG_FIX, {{(dctl_pkg::TIMEOUT_W-1){1'b0}}, drag_fix});
        send_idle_pct  = send_idle;
        recv_stall_pct = recv_stall;
        if (long_hold)
            hold_requests++;
        void'(add_random_events(60));
        wait_idle();
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default configuration: timeout off, all triggers and drag fix on
        add_event(dctl_pkg::OP_KEY_DOWN, dctl_pkg::KC_LCTRL);     // bare tap -> Escape
        add_event(dctl_pkg::OP_KEY_UP, dctl_pkg::KC_LCTRL);
        add_event(dctl_pkg::OP_KEY_DOWN, dctl_pkg::KC_LCTRL);
        add_event(dctl_pkg::OP_KEY_DOWN, KC_OTHER);               // key forces Ctrl out
        add_event(dctl_pkg::OP_KEY_UP, dctl_pkg::KC_LCTRL);
        add_event(dctl_pkg::OP_KEY_DOWN, dctl_pkg::KC_LCTRL);
        add_event(dctl_pkg::OP_KEY_DOWN, dctl_pkg::KC_LCTRL);     // repeated press while held
        add_event(dctl_pkg::OP_MOUSE_MOVE, KC_OTHER);             // mouse forces Ctrl out
        add_event(dctl_pkg::OP_KEY_DOWN, dctl_pkg::KC_LCTRL);     // repeated press, forwarded
        add_event(dctl_pkg::OP_KEY_UP, dctl_pkg::KC_LCTRL);
        add_event(dctl_pkg::OP_KEY_UP, dctl_pkg::KC_LCTRL);       // stray release
        add_event(dctl_pkg::OP_KEY_DOWN, dctl_pkg::KC_LALT);
        add_event(dctl_pkg::OP_KEY_DOWN, dctl_pkg::KC_LALT);      // repeated Alt press
        add_event(dctl_pkg::OP_KEY_DOWN, dctl_pkg::KC_LCTRL);
        add_event(dctl_pkg::OP_MOUSE_BUTTON, KC_OTHER);           // drag under Alt
        add_event(dctl_pkg::OP_KEY_UP, dctl_pkg::KC_LCTRL);
        add_event(dctl_pkg::OP_KEY_UP, dctl_pkg::KC_LALT);
        add_event(dctl_pkg::OP_KEY_DOWN, dctl_pkg::KC_LCTRL);     // after a drag -> right-Ctrl tap
        add_event(dctl_pkg::OP_KEY_UP, dctl_pkg::KC_LCTRL);
        add_event(dctl_pkg::OP_KEY_DOWN, dctl_pkg::KC_LALT);
        add_event(dctl_pkg::OP_KEY_DOWN, dctl_pkg::KC_LCTRL);
        add_event(dctl_pkg::OP_KEY_UP, dctl_pkg::KC_LCTRL);       // released under Alt
        add_event(dctl_pkg::OP_KEY_UP, dctl_pkg::KC_LALT);
        add_event(dctl_pkg::OP_TICK, KC_OTHER);
        add_event(dctl_pkg::OP_UNKNOWN, dctl_pkg::KC_LALT);
        add_event(OP_OTHER_MSG, dctl_pkg::KC_LCTRL);
        add_event(OP_SPARE, KC_SPARE);
        add_event(dctl_pkg::OP_KEY_DOWN, KC_SPARE);
        wait_idle();

        // Timeout forces a held Ctrl out after three ticks
        write_reg(dctl_pkg::REG_TIMEOUT, 16'd3);
        add_event(dctl_pkg::OP_KEY_DOWN, dctl_pkg::KC_LCTRL);
        add_event(dctl_pkg::OP_TICK, KC_OTHER);
        add_event(dctl_pkg::OP_TICK, KC_OTHER);
        add_event(dctl_pkg::OP_TICK, KC_OTHER);
        add_event(dctl_pkg::OP_KEY_UP, dctl_pkg::KC_LCTRL);
        wait_idle();

        run_phase(16'd0,    1'b1, 1'b1, 1'b1, 0,  0,  1'b0);
        run_phase(16'd2,    1'b0, 1'b1, 1'b1, 71, 0,  1'b0);
        run_phase(16'hFFFF, 1'b1, 1'b0, 1'b0, 0,  71, 1'b0);
        run_phase(16'd1,    1'b1, 1'b1, 1'b1, 6,  6,  1'b1);
        run_phase(16'd4,    1'b0, 1'b0, 1'b1, 30, 30, 1'b0);

        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
